// ===== rtl/core/ccs_pkg.sv =====
// Shared types and constants for the Chaikin curve subdivider.
// Used by ccs_cell and chaikin_curve_subdivider_unit; no dependencies.
package ccs_pkg;

  // Control part of a token moving between cells.
  // A token is either a point or a flush that only clears state downstream.
  typedef struct packed {
    logic valid;
    logic is_pt;
    logic last;
  } tok_t;

  localparam int LEVELS_W   = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (paddr[2] selects the word).
  localparam logic REG_SUBDIV_LEVELS = 1'b0;

endpackage

// ===== rtl/core/ccs_cell.sv =====
// One corner-cutting pass of the subdivider chain.
// Depends on ccs_pkg (tok_t). Holds the previous point, an output register
// and a pending slot for the second cut point.
module ccs_cell #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         active,
  input  ccs_pkg::tok_t                in_tok,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output logic                         in_ready,
  output ccs_pkg::tok_t                out_tok,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  input  logic                         out_ready
);

  ccs_pkg::tok_t out_tok_r, out_tok_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r, out_z_r;
  logic signed [COORD_BITS-1:0] out_x_nxt, out_y_nxt, out_z_nxt;
  logic pend_v_r, pend_v_nxt;
  logic pend_last_r, pend_last_nxt;
  logic signed [COORD_BITS-1:0] pend_x_r, pend_y_r, pend_z_r;
  logic signed [COORD_BITS-1:0] pend_x_nxt, pend_y_nxt, pend_z_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [COORD_BITS-1:0] prev_x_nxt, prev_y_nxt, prev_z_nxt;
  logic has_prev_r, has_prev_nxt;
  logic out_free, take;

  // floor((3p + q) / 4); the result always stays in range
  function automatic logic signed [COORD_BITS-1:0] cut(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] q
  );
    logic [COORD_BITS+1:0] pe, qe, s;
    pe = {{2{p[COORD_BITS-1]}}, p};
    qe = {{2{q[COORD_BITS-1]}}, q};
    s  = (pe << 1) + pe + qe;
    return s[COORD_BITS+1:2];
  endfunction

  assign out_free = !out_tok_r.valid || out_ready;
  assign in_ready = !pend_v_r && out_free;
  assign take     = in_tok.valid && in_ready;

  always_comb begin
    out_tok_nxt   = out_tok_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    pend_v_nxt    = pend_v_r;
    pend_last_nxt = pend_last_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    pend_z_nxt    = pend_z_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_z_nxt    = prev_z_r;
    has_prev_nxt  = has_prev_r;

    // advance the pending cut point or drop the transferred one
    if (out_free) begin
      if (pend_v_r) begin
        out_tok_nxt = ccs_pkg::tok_t'{valid: 1'b1, is_pt: 1'b1, last: pend_last_r};
        out_x_nxt   = pend_x_r;
        out_y_nxt   = pend_y_r;
        out_z_nxt   = pend_z_r;
        pend_v_nxt  = 1'b0;
      end else begin
        out_tok_nxt.valid = 1'b0;
      end
    end

    if (take) begin
      if (!in_tok.is_pt) begin
        out_tok_nxt  = ccs_pkg::tok_t'{valid: 1'b1, is_pt: 1'b0, last: 1'b1};
        has_prev_nxt = 1'b0;
      end else if (!active) begin
        out_tok_nxt = ccs_pkg::tok_t'{valid: 1'b1, is_pt: 1'b1, last: in_tok.last};
        out_x_nxt   = in_x;
        out_y_nxt   = in_y;
        out_z_nxt   = in_z;
        if (in_tok.last) begin
          has_prev_nxt = 1'b0;
        end
      end else begin
        prev_x_nxt   = in_x;
        prev_y_nxt   = in_y;
        prev_z_nxt   = in_z;
        has_prev_nxt = !in_tok.last;
        if (has_prev_r) begin
          out_tok_nxt   = ccs_pkg::tok_t'{valid: 1'b1, is_pt: 1'b1, last: 1'b0};
          out_x_nxt     = cut(prev_x_r, in_x);
          out_y_nxt     = cut(prev_y_r, in_y);
          out_z_nxt     = cut(prev_z_r, in_z);
          pend_v_nxt    = 1'b1;
          pend_last_nxt = in_tok.last;
          pend_x_nxt    = cut(in_x, prev_x_r);
          pend_y_nxt    = cut(in_y, prev_y_r);
          pend_z_nxt    = cut(in_z, prev_z_r);
        end else if (in_tok.last) begin
          // single point at this pass: nothing to emit, clear the passes below
          out_tok_nxt = ccs_pkg::tok_t'{valid: 1'b1, is_pt: 1'b0, last: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tok_r  <= '0;
      pend_v_r   <= 1'b0;
      has_prev_r <= 1'b0;
    end else begin
      out_tok_r  <= out_tok_nxt;
      pend_v_r   <= pend_v_nxt;
      has_prev_r <= has_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    pend_last_r <= pend_last_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_z_r    <= pend_z_nxt;
    prev_x_r    <= prev_x_nxt;
    prev_y_r    <= prev_y_nxt;
    prev_z_r    <= prev_z_nxt;
  end

  assign out_tok = out_tok_r;
  assign out_x   = out_x_r;
  assign out_y   = out_y_r;
  assign out_z   = out_z_r;

endmodule

// ===== rtl/core/chaikin_curve_subdivider_unit.sv =====
// Top level of the Chaikin corner-cutting subdivider for open 3-D curves.
// Depends on ccs_pkg and ccs_cell (a chain of MAX_LEVELS passes).
//
//  channel  handshake                         payload
//  in       in_valid / in_ready               in_coord_x/y/z, in_last_point
//  out      out_valid / out_ready             out_vert_x/y/z, out_last_vertex
//  cfg      cfg_psel/penable/pwrite, pready   cfg_paddr, cfg_pwdata, cfg_prdata
//
// An input point yields up to 2**L vertices at L active passes (L = 0: one vertex),
// so it can occupy the output for up to 2**L vertices, 64 at six passes.
// Each cell registers its output. The last cell's output register sets the pace:
// one vertex a cycle while out_ready is high.
// A bypassed pass takes a point every cycle; a cutting pass holds its input while
// the second cut point goes out, and every pass holds when its neighbor stalls.
// Reset (rst_n low, synchronous) clears all passes and sets subdiv_levels to zero.
module chaikin_curve_subdivider_unit #(
  parameter int MAX_LEVELS = 6,
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  input  logic signed [COORD_BITS-1:0]        in_coord_z,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_BITS-1:0]        out_vert_x,
  output logic signed [COORD_BITS-1:0]        out_vert_y,
  output logic signed [COORD_BITS-1:0]        out_vert_z,
  output logic                                out_last_vertex,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ccs_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [ccs_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  logic [ccs_pkg::LEVELS_W-1:0] levels_r, levels_nxt;
  logic cfg_wr;

  ccs_pkg::tok_t                lnk_tok [MAX_LEVELS+1];
  logic signed [COORD_BITS-1:0] lnk_x   [MAX_LEVELS+1];
  logic signed [COORD_BITS-1:0] lnk_y   [MAX_LEVELS+1];
  logic signed [COORD_BITS-1:0] lnk_z   [MAX_LEVELS+1];
  logic                         lnk_rdy [MAX_LEVELS+1];
  logic [MAX_LEVELS-1:0]        cell_act;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == ccs_pkg::REG_SUBDIV_LEVELS);

  always_comb begin
    levels_nxt = levels_r;
    if (cfg_wr) begin
      levels_nxt = cfg_pwdata[ccs_pkg::LEVELS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
    end else begin
      levels_r <= levels_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == ccs_pkg::REG_SUBDIV_LEVELS) begin
      cfg_prdata[ccs_pkg::LEVELS_W-1:0] = levels_r;
    end
  end

  // chain head: every input transfer is a point
  assign lnk_tok[0] = ccs_pkg::tok_t'{valid: in_valid, is_pt: 1'b1, last: in_last_point};
  assign lnk_x[0]   = in_coord_x;
  assign lnk_y[0]   = in_coord_y;
  assign lnk_z[0]   = in_coord_z;
  assign in_ready   = lnk_rdy[0];

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    // counts above MAX_LEVELS leave every pass active
    assign cell_act[i] = (int'(levels_r) > i);

    ccs_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (cell_act[i]),
      .in_tok   (lnk_tok[i]),
      .in_x     (lnk_x[i]),
      .in_y     (lnk_y[i]),
      .in_z     (lnk_z[i]),
      .in_ready (lnk_rdy[i]),
      .out_tok  (lnk_tok[i+1]),
      .out_x    (lnk_x[i+1]),
      .out_y    (lnk_y[i+1]),
      .out_z    (lnk_z[i+1]),
      .out_ready(lnk_rdy[i+1])
    );
  end

  // chain tail: drop flush tokens, present points
  assign lnk_rdy[MAX_LEVELS] = out_ready || !lnk_tok[MAX_LEVELS].is_pt;
  assign out_valid       = lnk_tok[MAX_LEVELS].valid && lnk_tok[MAX_LEVELS].is_pt;
  assign out_vert_x      = lnk_x[MAX_LEVELS];
  assign out_vert_y      = lnk_y[MAX_LEVELS];
  assign out_vert_z      = lnk_z[MAX_LEVELS];
  assign out_last_vertex = lnk_tok[MAX_LEVELS].last;

  // a flush token only ever comes from a last marker
  a_flush_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (lnk_tok[MAX_LEVELS].valid && !lnk_tok[MAX_LEVELS].is_pt) |-> lnk_tok[MAX_LEVELS].last)
    else $error("flush token without last marker at chain tail");

  // an idle first pass forwards the point in the next cycle
  a_bypass_forwards: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cell_act[0]) |=> (lnk_tok[1].valid && lnk_tok[1].is_pt))
    else $error("inactive first pass did not forward the point");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (levels_r == $past(cfg_pwdata[ccs_pkg::LEVELS_W-1:0])))
    else $error("subdiv_levels write lost");

endmodule

// ===== sim/chaikin_curve_subdivider_unit_tb.sv =====
// Self-checking testbench for the Chaikin curve subdivider top level.
// Needs ccs_pkg and chaikin_curve_subdivider_unit; predicts every vertex and
// checks it against the output stream under random input gaps and output stalls.
module chaikin_curve_subdivider_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEVELS    = 6;
  localparam int COORD_BITS    = 24;
  localparam int SETTLE_CYCLES = 4 * MAX_LEVELS + 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 340;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vertex_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t in_coord_x = '0;
  coord_t in_coord_y = '0;
  coord_t in_coord_z = '0;
  logic   in_last_point = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_vert_x;
  coord_t out_vert_y;
  coord_t out_vert_z;
  logic   out_last_vertex;
  logic   cfg_psel = 1'b0;
  logic   cfg_penable = 1'b0;
  logic   cfg_pwrite = 1'b0;
  logic [ccs_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic   cfg_pready;

  // Predictor state: one held point per pass plus the level register.
  vertex_t    held_pt [MAX_LEVELS];
  logic       has_held [MAX_LEVELS];
  logic [2:0] levels_cfg = '0;
  vertex_t    vert_expected [$];

  int          failures = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  logic [15:0] ready_tick = '0;
  stall_mode_t stall_mode = STALL_NONE;

  chaikin_curve_subdivider_unit #(
    .MAX_LEVELS(MAX_LEVELS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z),
    .in_last_point(in_last_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_vert_x(out_vert_x),
    .out_vert_y(out_vert_y),
    .out_vert_z(out_vert_z),
    .out_last_vertex(out_last_vertex),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // floor((3*near + far) / 4); the arithmetic shift rounds toward minus infinity
  function automatic coord_t quarter_mix(input coord_t near_pt, input coord_t far_pt);
    int acc;
    acc = 3 * int'(near_pt) + int'(far_pt);
    return coord_t'(acc >>> 2);
  endfunction

  // Run one point through the active passes and queue the vertices it yields.
  function automatic void cut_corners(input coord_t x, input coord_t y, input coord_t z,
                                      input logic last);
    vertex_t pts [$];
    vertex_t nxt [$];
    vertex_t pa;
    vertex_t pb;
    int      active;
    active = (levels_cfg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_cfg);
    pts.push_back('{x, y, z, 1'b0});
    for (int s = 0; s < active; s++) begin
      nxt.delete();
      foreach (pts[i]) begin
        if (!has_held[s]) begin
          has_held[s] = 1'b1;
        end else begin
          pa = '{quarter_mix(held_pt[s].x, pts[i].x), quarter_mix(held_pt[s].y, pts[i].y),
                 quarter_mix(held_pt[s].z, pts[i].z), 1'b0};
          pb = '{quarter_mix(pts[i].x, held_pt[s].x), quarter_mix(pts[i].y, held_pt[s].y),
                 quarter_mix(pts[i].z, held_pt[s].z), 1'b0};
          nxt.push_back(pa);
          nxt.push_back(pb);
        end
        held_pt[s] = pts[i];
      end
      pts = nxt;
    end
    if (last) begin
      if (pts.size() > 0) pts[pts.size()-1].last = 1'b1;
      for (int s = 0; s < MAX_LEVELS; s++) begin
        has_held[s] = 1'b0;
        held_pt[s] = '0;
      end
    end
    foreach (pts[i]) vert_expected.push_back(pts[i]);
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  function automatic void check_vertex();
    vertex_t got;
    vertex_t want;
    got = '{out_vert_x, out_vert_y, out_vert_z, out_last_vertex};
    if (vert_expected.size() == 0) begin
      note_failure($sformatf("unexpected vertex x=%0d y=%0d z=%0d last=%b",
                             got.x, got.y, got.z, got.last));
    end else begin
      want = vert_expected.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.last !== want.last)
        note_failure($sformatf({"vertex mismatch: exp x=%0d y=%0d z=%0d last=%b, ",
                                "got x=%0d y=%0d z=%0d last=%b"},
                               want.x, want.y, want.z, want.last,
                               got.x, got.y, got.z, got.last));
    end
  endfunction

  // Predict on each input transfer, check on each output transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        cut_corners(in_coord_x, in_coord_y, in_coord_z, in_last_point);
      if (out_valid && out_ready)
        check_vertex();
    end
  end

  // Receiver back-pressure, switching to a random pattern whenever ready_tick[7:0] wraps to zero.
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    if (ready_tick[7:0] == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_ready <= 1'b1;
      STALL_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_ready <= (ready_tick[2:0] > 3'd2);
      default:        out_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1:    return coord_t'($urandom);
      2:       return coord_t'($urandom_range(0, 64)) - coord_t'(32);
      3:       return COORD_MAX;
      4:       return COORD_MIN;
      default: return $urandom_range(0, 1) ? COORD_MAX - coord_t'($urandom_range(0, 7))
                                           : COORD_MIN + coord_t'($urandom_range(0, 7));
    endcase
  endfunction

  // Send one point; bursts of random length with random gaps between them.
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Hold the sender until every predicted vertex is out, then let the passes settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vert_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(input logic [2:0] lvl, input bit junk_upper);
    logic [ccs_pkg::CFG_DATA_W-1:0] word;
    word = junk_upper ? ccs_pkg::CFG_DATA_W'($urandom) : '0;
    word[2:0] = lvl;
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {ccs_pkg::REG_SUBDIV_LEVELS, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    levels_cfg = word[2:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic test_zero_passes();
    write_levels(3'd0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_point(coord_t'(0), coord_t'(-1), coord_t'(1), 1'b0);
    send_point(coord_t'(24'h555555), coord_t'(24'haaaaaa), coord_t'(24'h5a5a5a), 1'b1);
  endtask

  // A lone point is only stored, and its last marker flags nothing.
  task automatic test_single_point_curves();
    write_levels(3'd2, 1'b0);
    send_point(COORD_MIN, COORD_MAX, coord_t'(0), 1'b1);
    send_point(COORD_MAX, COORD_MIN, coord_t'(-1), 1'b1);
  endtask

  task automatic test_corner_extremes();
    write_levels(3'd1, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    write_levels(3'd6, 1'b1);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, coord_t'(-1), 1'b1);
  endtask

  // A level value above the pass count behaves as the full count.
  task automatic test_saturated_levels();
    write_levels(3'd7, 1'b0);
    send_point(coord_t'(-5), coord_t'(7), coord_t'(-3), 1'b0);
    send_point(coord_t'(3), coord_t'(-9), coord_t'(2), 1'b1);
  endtask

  // Change the level count with curves left open; passes keep their points.
  task automatic test_level_change_mid_curve();
    write_levels(3'd2, 1'b0);
    send_point(coord_t'(100), coord_t'(-100), coord_t'(7), 1'b0);
    send_point(coord_t'(-37), coord_t'(250), coord_t'(-1), 1'b0);
    write_levels(3'd4, 1'b1);
    send_point(coord_t'(11), coord_t'(13), coord_t'(-17), 1'b0);
    write_levels(3'd0, 1'b0);
    send_point(coord_t'(2), coord_t'(-2), coord_t'(9), 1'b0);
    write_levels(3'd3, 1'b0);
    send_point(coord_t'(-64), coord_t'(64), coord_t'(0), 1'b1);
  endtask

  task automatic test_random_curves();
    int         sent;
    int         phase;
    int         phase_items;
    int         curve_len;
    logic [2:0] lvl;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      lvl = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
      write_levels(lvl, ($urandom_range(0, 1) == 1));
      // keep the 64-vertex settings short
      phase_items = (lvl >= 3'd6) ? $urandom_range(4, 10) : $urandom_range(15, 40);
      while (phase_items > 0 && sent < RANDOM_ITEMS) begin
        curve_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
        for (int i = 0; i < curve_len && phase_items > 0; i++) begin
          // drop the last marker now and then so curves run together
          send_point(rand_coord(), rand_coord(), rand_coord(),
                     (i == curve_len - 1) && ($urandom_range(0, 9) != 0));
          sent++;
          phase_items--;
        end
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
      phase++;
    end
  endtask

  initial begin
    for (int s = 0; s < MAX_LEVELS; s++) begin
      held_pt[s] = '0;
      has_held[s] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_passes();
    test_single_point_curves();
    test_corner_extremes();
    test_saturated_levels();
    test_level_change_mid_curve();
    test_random_curves();
    wait_drained();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
